/* rtl/core/cdf97_pkg.sv */
package cdf97_pkg;

  localparam int MAX_LEN_DEF = 64;

  // Item and buffer formats: Q16.8 samples, Q24.8 buffer words, Q2.16 coefficients.
  localparam int DATA_W  = 24;
  localparam int WORD_W  = 32;
  localparam int COEF_W  = 18;
  localparam int FRAC_W  = 16;
  localparam int OPND_W  = WORD_W + 1;
  localparam int PROD_W  = OPND_W + COEF_W;
  localparam int D_W     = PROD_W - FRAC_W;
  localparam int RES_W   = D_W + 1;

  localparam logic signed [PROD_W-1:0] PROD_ROUND = PROD_W'(1) <<< (FRAC_W - 1);

  // Configuration port.
  localparam int CFG_AW  = 3;
  localparam int PDATA_W = 32;
  localparam int HL_W    = 6;
  localparam logic [HL_W-1:0] HL_RESET = HL_W'(32);

  typedef enum logic {
    REG_HALF_LENGTH,
    REG_DIRECTION
  } reg_idx_e;

  // Lifting and scaling constants.
  localparam logic signed [COEF_W-1:0] C_A1  = -18'sd103949;
  localparam logic signed [COEF_W-1:0] C_A2  = -18'sd3472;
  localparam logic signed [COEF_W-1:0] C_A3  = 18'sd57862;
  localparam logic signed [COEF_W-1:0] C_A4  = 18'sd29066;
  localparam logic signed [COEF_W-1:0] C_K1  = 18'sd53274;
  localparam logic signed [COEF_W-1:0] C_K2  = 18'sd40310;
  localparam logic signed [COEF_W-1:0] C_IK1 = 18'sd80621;
  localparam logic signed [COEF_W-1:0] C_IK2 = 18'sd106548;

  // Passes over the buffer. Forward starts at the first lifting pass.
  localparam logic [2:0] PASS_SCALE = 3'd0;
  localparam logic [2:0] PASS_LIFT1 = 3'd1;
  localparam logic [2:0] PASS_LIFT2 = 3'd2;
  localparam logic [2:0] PASS_LIFT3 = 3'd3;
  localparam logic [2:0] PASS_LIFT4 = 3'd4;
  localparam logic [2:0] PASS_OUT   = 3'd5;

  typedef enum logic [1:0] {
    PK_SCALE,
    PK_LIFT,
    PK_OUT
  } pass_kind_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_PASS
  } op_e;

  typedef struct packed {
    pass_kind_e                kind;
    logic                      parity;
    op_e                       op;
    logic                      emit;
    logic signed [COEF_W-1:0]  coef_lo;
    logic signed [COEF_W-1:0]  coef_hi;
  } pass_cfg_t;

  function automatic pass_cfg_t pass_cfg(input logic inv, input logic [2:0] pass);
    pass_cfg_t pc;
    pc.kind    = PK_LIFT;
    pc.parity  = inv ? ~pass[0] : pass[0];
    pc.op      = inv ? OP_SUB : OP_ADD;
    pc.emit    = 1'b0;
    pc.coef_lo = C_A1;
    pc.coef_hi = C_A1;
    case (pass)
      PASS_SCALE: begin
        pc.kind    = PK_SCALE;
        pc.parity  = 1'b0;
        pc.op      = OP_MUL;
        pc.coef_lo = C_IK1;
        pc.coef_hi = C_IK2;
      end
      PASS_LIFT1: begin
        pc.coef_lo = inv ? C_A4 : C_A1;
        pc.coef_hi = pc.coef_lo;
      end
      PASS_LIFT2: begin
        pc.coef_lo = inv ? C_A3 : C_A2;
        pc.coef_hi = pc.coef_lo;
      end
      PASS_LIFT3: begin
        pc.coef_lo = inv ? C_A2 : C_A3;
        pc.coef_hi = pc.coef_lo;
      end
      PASS_LIFT4: begin
        pc.coef_lo = inv ? C_A1 : C_A4;
        pc.coef_hi = pc.coef_lo;
      end
      PASS_OUT: begin
        pc.kind    = PK_OUT;
        pc.parity  = 1'b0;
        pc.op      = inv ? OP_PASS : OP_MUL;
        pc.emit    = 1'b1;
        pc.coef_lo = C_K1;
        pc.coef_hi = C_K2;
      end
      default: ;
    endcase
    return pc;
  endfunction

endpackage

/* rtl/core/cdf97_lifting_1d_unit.sv */
// One level of the CDF 9/7 lifting wavelet over a signal of 2*h samples (h = half_length,
// 0 read as 1, capped at MAX_LEN/2), one sample per item on start/busy. Samples go straight
// into a buffer RAM with two read ports and one write port, one per cycle. The item that
// completes the signal raises busy, and the signal is then worked in passes over that RAM
// through a four-stage read, add, multiply, write-back pipeline that takes one element per
// cycle; each pass drains the pipeline before the next. Forward mode runs four lifting
// passes (h elements each, plus a priming fetch for odd passes) and an output pass of 2h
// elements. Inverse mode adds a scaling pass over all 2h elements. Results come out in
// the output pass, one per cycle on valid_o, low band then high band (forward) or in
// signal order (inverse), with last_o on the final one. The receiver cannot stall them:
// each result is present for one cycle only. busy stays high until the last result has
// been shown. Configuration is sampled when the signal completes.
module cdf97_lifting_1d_unit #(
  parameter int MAX_LEN = cdf97_pkg::MAX_LEN_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [cdf97_pkg::CFG_AW-1:0]          paddr,
  input  logic [cdf97_pkg::PDATA_W-1:0]         pwdata,
  output logic [cdf97_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [cdf97_pkg::DATA_W-1:0]   sample_i,
  output logic                                  valid_o,
  output logic signed [cdf97_pkg::DATA_W-1:0]   value_o,
  output logic                                  last_o
);
  import cdf97_pkg::*;

  localparam int AW   = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int HMAX = MAX_LEN / 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic                     emit;
    logic                     last;
    logic                     first;
    logic                     prime;
    logic signed [COEF_W-1:0] coef;
    logic [AW-1:0]            addr;
  } beat_t;

  // Logical signal position to buffer address. In inverse mode the buffer keeps the
  // load order: low band in the first h entries, high band after it.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] j, input logic inv,
                                         input logic [AW-1:0] h);
    logic [AW-1:0] half;
    half = j >> 1;
    if (!inv) begin
      return j;
    end else if (j[0]) begin
      return h + half;
    end else begin
      return half;
    end
  endfunction

  // Configuration registers.
  logic [HL_W-1:0] half_length_q;
  logic            direction_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q <= HL_RESET;
      direction_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[CFG_AW-1]))
        REG_HALF_LENGTH: half_length_q <= pwdata[HL_W-1:0];
        REG_DIRECTION:   direction_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[CFG_AW-1]))
      REG_HALF_LENGTH: prdata = PDATA_W'(half_length_q);
      REG_DIRECTION:   prdata = PDATA_W'(direction_q);
      default:         prdata = '0;
    endcase
  end

  logic [AW-1:0] h_eff;
  logic [AW:0]   n_eff;

  always_comb begin
    if (half_length_q == '0) begin
      h_eff = AW'(1);
    end else if (half_length_q > HL_W'(HMAX)) begin
      h_eff = AW'(HMAX);
    end else begin
      h_eff = half_length_q[AW-1:0];
    end
  end
  assign n_eff = {h_eff, 1'b0};

  // Sequencer state.
  state_e        state_q;
  logic [2:0]    pass_q;
  logic [AW-1:0] cnt_q;
  logic          prime_q;
  logic [AW-1:0] h_q;
  logic          inv_q;
  logic [AW:0]   load_q;

  pass_cfg_t     pcfg;
  pass_cfg_t     pcfg_next;
  pass_cfg_t     pcfg_start;
  logic [2:0]    pass_start;
  logic          load_fire;
  logic [AW:0]   load_inc;
  logic [AW:0]   n_m1;
  logic [AW-1:0] h_m1;
  logic          lo_half;
  logic          last_beat;
  logic [AW-1:0] i_lift;
  logic [AW-1:0] b_lift;
  logic [AW-1:0] j_fwd;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  beat_t         beat;

  assign busy       = (state_q != ST_LOAD);
  assign load_fire  = start & ~busy;
  assign load_inc   = load_q + 1'b1;
  assign pass_start = direction_q ? PASS_SCALE : PASS_LIFT1;
  assign pcfg       = pass_cfg(inv_q, pass_q);
  assign pcfg_next  = pass_cfg(inv_q, 3'(pass_q + 3'd1));
  assign pcfg_start = pass_cfg(direction_q, pass_start);
  assign n_m1       = {h_q, 1'b0} - 1'b1;
  assign h_m1       = h_q - 1'b1;
  assign lo_half    = (cnt_q < h_q);
  assign i_lift     = AW'({cnt_q, pcfg.parity});
  // At the right end of an odd pass the mirrored neighbor is the left one.
  assign b_lift     = (pcfg.parity && cnt_q == h_m1) ? i_lift - 1'b1 : i_lift + 1'b1;
  assign j_fwd      = lo_half ? AW'({cnt_q, 1'b0}) : AW'({AW'(cnt_q - h_q), 1'b1});

  always_comb begin
    addr_a     = cnt_q;
    addr_b     = '0;
    last_beat  = ({1'b0, cnt_q} == n_m1);
    beat.op    = pcfg.op;
    beat.emit  = pcfg.emit;
    beat.last  = 1'b0;
    beat.first = 1'b0;
    beat.prime = 1'b0;
    beat.coef  = lo_half ? pcfg.coef_lo : pcfg.coef_hi;
    beat.addr  = cnt_q;
    case (pcfg.kind)
      PK_LIFT: begin
        if (prime_q) begin
          // Odd passes start by fetching position 0 as the first left neighbor.
          beat.prime = 1'b1;
          last_beat  = 1'b0;
        end else begin
          addr_a     = phys(i_lift, inv_q, h_q);
          addr_b     = phys(b_lift, inv_q, h_q);
          beat.first = ~pcfg.parity & (cnt_q == '0);
          last_beat  = (cnt_q == h_m1);
          beat.addr  = addr_a;
        end
      end
      PK_OUT: begin
        addr_a    = inv_q ? phys(cnt_q, inv_q, h_q) : j_fwd;
        beat.last = last_beat;
        beat.addr = addr_a;
      end
      default: ;
    endcase
  end

  // Pipeline: p1 holds RAM read data, p2 the multiplier operand, p3 the rounded product.
  logic                     p1_v_q, p2_v_q, p3_v_q;
  beat_t                    p1_q, p2_q, p3_q;
  logic signed [WORD_W-1:0] rd_a_q, rd_b_q, prev_b_q;
  logic signed [WORD_W-1:0] w2_q, w3_q;
  logic signed [OPND_W-1:0] opnd2_q;
  logic signed [D_W-1:0]    d3_q;
  logic                     pipe_busy;

  logic signed [WORD_W-1:0] left1;
  logic signed [OPND_W-1:0] opnd1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] prod2_r;
  logic signed [RES_W-1:0]  res3;
  logic signed [WORD_W-1:0] sat32_3;
  logic signed [DATA_W-1:0] sat24_3;

  assign pipe_busy = p1_v_q | p2_v_q | p3_v_q;

  always_comb begin
    left1 = p1_q.first ? rd_b_q : prev_b_q;
    if (p1_q.op == OP_ADD || p1_q.op == OP_SUB) begin
      opnd1 = OPND_W'(left1) + OPND_W'(rd_b_q);
    end else begin
      opnd1 = OPND_W'(rd_a_q);
    end
  end

  assign prod2   = $signed(p2_q.coef) * opnd2_q;
  assign prod2_r = prod2 + PROD_ROUND;

  always_comb begin
    case (p3_q.op)
      OP_ADD:  res3 = RES_W'(w3_q) + RES_W'(d3_q);
      OP_SUB:  res3 = RES_W'(w3_q) - RES_W'(d3_q);
      OP_MUL:  res3 = RES_W'(d3_q);
      OP_PASS: res3 = RES_W'(w3_q);
      default: res3 = RES_W'(w3_q);
    endcase
    if (res3[RES_W-1:WORD_W-1] != {(RES_W-WORD_W+1){res3[RES_W-1]}}) begin
      sat32_3 = res3[RES_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat32_3 = res3[WORD_W-1:0];
    end
    if (res3[RES_W-1:DATA_W-1] != {(RES_W-DATA_W+1){res3[RES_W-1]}}) begin
      sat24_3 = res3[RES_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat24_3 = res3[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p1_v_q <= (state_q == ST_ISSUE);
      p2_v_q <= p1_v_q & ~p1_q.prime;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= beat;
    if (p1_v_q) begin
      prev_b_q <= rd_b_q;
    end
    p2_q    <= p1_q;
    w2_q    <= rd_a_q;
    opnd2_q <= opnd1;
    p3_q    <= p2_q;
    w3_q    <= w2_q;
    d3_q    <= prod2_r[PROD_W-1:FRAC_W];
  end

  // Work buffer RAM: one write port, two registered read ports.
  logic [WORD_W-1:0] mem [MAX_LEN];
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [WORD_W-1:0] mem_wd;

  assign mem_we = load_fire | (p3_v_q & ~p3_q.emit);
  assign mem_wa = load_fire ? load_q[AW-1:0] : p3_q.addr;
  assign mem_wd = load_fire ? {{(WORD_W-DATA_W){sample_i[DATA_W-1]}}, sample_i} : sat32_3;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pass_q  <= PASS_SCALE;
      cnt_q   <= '0;
      prime_q <= 1'b0;
      h_q     <= '0;
      inv_q   <= 1'b0;
      load_q  <= '0;
      valid_o <= 1'b0;
      value_o <= '0;
      last_o  <= 1'b0;
    end else begin
      valid_o <= p3_v_q & p3_q.emit;
      value_o <= sat24_3;
      last_o  <= p3_v_q & p3_q.emit & p3_q.last;
      case (state_q)
        ST_LOAD: begin
          if (load_fire) begin
            if (load_inc >= n_eff) begin
              load_q  <= '0;
              h_q     <= h_eff;
              inv_q   <= direction_q;
              pass_q  <= pass_start;
              cnt_q   <= '0;
              prime_q <= (pcfg_start.kind == PK_LIFT) & pcfg_start.parity;
              state_q <= ST_ISSUE;
            end else begin
              load_q <= load_inc;
            end
          end
        end
        ST_ISSUE: begin
          if (prime_q && pcfg.kind == PK_LIFT) begin
            prime_q <= 1'b0;
          end else if (last_beat) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The next pass reads what this one wrote, so wait for the last write-back.
          if (!pipe_busy) begin
            if (pass_q == PASS_OUT) begin
              state_q <= ST_LOAD;
            end else begin
              pass_q  <= 3'(pass_q + 3'd1);
              cnt_q   <= '0;
              prime_q <= (pcfg_next.kind == PK_LIFT) & pcfg_next.parity;
              state_q <= ST_ISSUE;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

/* dv/cdf97_lifting_1d_unit_tb.sv */
module cdf97_lifting_1d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdf97_pkg::*;

  localparam int ITEM_TARGET  = 460;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int IDLE_PCT [4] = '{0, 59, 0, 7};

  // Q2.16 lifting and scaling coefficients.
  localparam longint LIFT_A1  = -103949;
  localparam longint LIFT_A2  = -3472;
  localparam longint LIFT_A3  = 57862;
  localparam longint LIFT_A4  = 29066;
  localparam longint SCALE_K1 = 53274;
  localparam longint SCALE_K2 = 40310;
  localparam longint UNSCL_K1 = 80621;
  localparam longint UNSCL_K2 = 106548;

  localparam logic signed [DATA_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN = 24'sh800000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } coef_t;

  typedef struct packed {
    logic                     cfg;
    logic [HL_W-1:0]          half;
    logic                     inv;
    logic signed [DATA_W-1:0] smp;
    logic                     typed;
    logic signed [DATA_W-1:0] want;
  } dir_row_t;

  // A row with cfg set reprograms the block before its sample is sent. Rows with typed
  // set carry the value that every result of the completed signal must show.
  localparam dir_row_t DIR_ROWS [24] = '{
    '{1'b1, 6'd1,  1'b0, 24'sd0,       1'b1, 24'sd0},
    '{1'b0, 6'd1,  1'b0, 24'sd0,       1'b1, 24'sd0},
    '{1'b1, 6'd1,  1'b1, 24'sd0,       1'b1, 24'sd0},
    '{1'b0, 6'd1,  1'b1, 24'sd0,       1'b1, 24'sd0},
    '{1'b1, 6'd0,  1'b0, SMAX,         1'b0, 24'sd0},
    '{1'b0, 6'd0,  1'b0, SMIN,         1'b0, 24'sd0},
    '{1'b1, 6'd2,  1'b0, SMAX,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b0, SMIN,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b0, SMAX,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b0, SMIN,         1'b0, 24'sd0},
    '{1'b1, 6'd2,  1'b1, SMIN,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b1, SMAX,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b1, SMIN,         1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b1, SMAX,         1'b0, 24'sd0},
    '{1'b1, 6'd63, 1'b0, 24'sd256,     1'b0, 24'sd0},
    '{1'b0, 6'd63, 1'b0, -24'sd256,    1'b0, 24'sd0},
    '{1'b0, 6'd63, 1'b0, 24'sd1,       1'b0, 24'sd0},
    '{1'b1, 6'd1,  1'b0, 24'sd12345,   1'b0, 24'sd0},
    '{1'b1, 6'd2,  1'b0, 24'sd986895,  1'b0, 24'sd0},
    '{1'b0, 6'd2,  1'b0, -24'sd986895, 1'b0, 24'sd0},
    '{1'b1, 6'd3,  1'b1, 24'sd8043742, 1'b0, 24'sd0},
    '{1'b0, 6'd3,  1'b1, -24'sd100000, 1'b0, 24'sd0},
    '{1'b0, 6'd3,  1'b1, 24'sd77,      1'b0, 24'sd0},
    '{1'b0, 6'd3,  1'b1, 24'sd4194304, 1'b0, 24'sd0}
  };

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [CFG_AW-1:0]        paddr   = '0;
  logic [PDATA_W-1:0]       pwdata  = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     start   = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] sample_i = '0;
  logic                     valid_o;
  logic signed [DATA_W-1:0] value_o;
  logic                     last_o;

  // Travel with each item so the monitor sees the same typed expectation as the sample.
  logic                     typed_q   = 1'b0;
  logic signed [DATA_W-1:0] typed_val = '0;

  // Mirror of the registers and the block's load state.
  logic [HL_W-1:0] cfg_half = HL_RESET;
  logic            cfg_inv  = 1'b0;
  int              sig_buf [64];
  int              wave [64];
  int              load_cnt = 0;

  coef_t pending_coefs [$];

  int n_errors  = 0;
  int n_items   = 0;
  int n_checked = 0;
  int n_fwd_sig = 0;
  int n_inv_sig = 0;
  int sent      = 0;
  int stall_cnt = 0;

  cdf97_lifting_1d_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .sample_i (sample_i),
    .valid_o  (valid_o),
    .value_o  (value_o),
    .last_o   (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Round half up: add half an LSB, then floor the shift.
  function automatic longint qmul(input longint c, input longint x);
    return (c * x + 64'sd32768) >>> 16;
  endfunction

  function automatic int sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(input longint v);
    if (v > 64'sd8388607) return SMAX;
    if (v < -64'sd8388608) return SMIN;
    return DATA_W'(v);
  endfunction

  // One predict or update step over the positions of one parity. The missing neighbor at
  // either end is the mirrored one.
  function automatic void lift_pass(input int par, input longint coef, input bit undo,
                                    input int n);
    longint left, right, d;
    for (int i = par; i < n; i += 2) begin
      left  = (i > 0) ? wave[i-1] : wave[i+1];
      right = (i + 1 < n) ? wave[i+1] : wave[i-1];
      d = qmul(coef, left + right);
      wave[i] = sat32(undo ? longint'(wave[i]) - d : longint'(wave[i]) + d);
    end
  endfunction

  function automatic void push_coef(input logic signed [DATA_W-1:0] v, input bit fin,
                                    input bit typed, input logic signed [DATA_W-1:0] tv);
    coef_t c;
    c.value = typed ? tv : v;
    c.last  = fin;
    pending_coefs.push_back(c);
  endfunction

  // Buffers one sample and, when it completes the signal, queues the whole transform.
  function automatic void lift_predict(input logic signed [DATA_W-1:0] s, input bit typed,
                                       input logic signed [DATA_W-1:0] tv);
    int h, n;
    h = int'(cfg_half);
    if (h < 1) h = 1;
    if (h > 32) h = 32;
    n = 2 * h;
    sig_buf[load_cnt % 64] = int'(s);
    load_cnt++;
    if (load_cnt < n) return;
    load_cnt = 0;
    if (!cfg_inv) begin
      n_fwd_sig++;
      for (int i = 0; i < n; i++) wave[i] = sig_buf[i];
      lift_pass(1, LIFT_A1, 1'b0, n);
      lift_pass(0, LIFT_A2, 1'b0, n);
      lift_pass(1, LIFT_A3, 1'b0, n);
      lift_pass(0, LIFT_A4, 1'b0, n);
      for (int i = 0; i < h; i++)
        push_coef(sat24(qmul(SCALE_K1, wave[2*i])), 1'b0, typed, tv);
      for (int i = 0; i < h; i++)
        push_coef(sat24(qmul(SCALE_K2, wave[2*i+1])), i == h - 1, typed, tv);
    end else begin
      n_inv_sig++;
      for (int i = 0; i < h; i++) begin
        wave[2*i]   = sat32(qmul(UNSCL_K1, sig_buf[i]));
        wave[2*i+1] = sat32(qmul(UNSCL_K2, sig_buf[h+i]));
      end
      lift_pass(0, LIFT_A4, 1'b1, n);
      lift_pass(1, LIFT_A3, 1'b1, n);
      lift_pass(0, LIFT_A2, 1'b1, n);
      lift_pass(1, LIFT_A1, 1'b1, n);
      for (int i = 0; i < n; i++) push_coef(sat24(wave[i]), i == n - 1, typed, tv);
    end
  endfunction

  always @(posedge clk_i) begin
    coef_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        n_items++;
        lift_predict(sample_i, typed_q, typed_val);
      end
      if (valid_o) begin
        if (pending_coefs.size() == 0) begin
          $error("unexpected result: value %0d last %0b", value_o, last_o);
          n_errors++;
        end else begin
          want = pending_coefs.pop_front();
          n_checked++;
          if (value_o !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_o);
            n_errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            n_errors++;
          end
        end
      end
    end
  end

  // Nothing accepted for too long means the block has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (psel && penable && pready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic apb_access(input bit wr, input reg_idx_e idx, input logic [PDATA_W-1:0] wd,
                            output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), want, rd);
      n_errors++;
    end
  endtask

  // Upper data bits are random; only the register's own bits may stick.
  task automatic write_reg(input reg_idx_e idx, input logic [HL_W-1:0] v);
    logic [PDATA_W-1:0] wd, rd, keep;
    keep = (idx == REG_HALF_LENGTH) ? PDATA_W'({HL_W{1'b1}}) : PDATA_W'(1);
    wd = ($urandom & ~keep) | (PDATA_W'(v) & keep);
    apb_access(1'b1, idx, wd, rd);
    if (idx == REG_HALF_LENGTH) cfg_half = v;
    else cfg_inv = v[0];
    check_reg(idx, wd & keep);
  endtask

  // Waits until every queued result is out and any trailing work has finished, then writes both registers.
  task automatic set_mode(input logic [HL_W-1:0] h, input logic inv);
    start <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    write_reg(REG_HALF_LENGTH, h);
    write_reg(REG_DIRECTION, {{(HL_W-1){1'b0}}, inv});
  endtask

  task automatic drive_sample(input logic signed [DATA_W-1:0] s, input bit typed,
                              input logic signed [DATA_W-1:0] tv, input int idle_pct);
    int gap;
    start     <= 1'b1;
    sample_i  <= s;
    typed_q   <= typed;
    typed_val <= tv;
    do @(posedge clk_i); while (busy);
    sent++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SMAX;
      1: return SMIN;
      2, 3, 4, 5: return DATA_W'($urandom);
      default: return DATA_W'(int'($urandom_range(8191)) - 4096);
    endcase
  endfunction

  initial begin
    int               phase, n, sigs, r, pct;
    logic [HL_W-1:0]  h;
    logic             inv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(REG_HALF_LENGTH, PDATA_W'(HL_RESET));
    check_reg(REG_DIRECTION, '0);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].cfg) set_mode(DIR_ROWS[i].half, DIR_ROWS[i].inv);
      drive_sample(DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].want, 0);
    end

    // Mostly short signals; now and then a full-length one, a zero length, or a setting
    // above the cap. Some phases stop part way into a signal so that the next setting
    // lands on a partly loaded buffer.
    phase = 0;
    while (sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 70) h = HL_W'($urandom_range(1, 8));
      else if (r < 88) h = HL_W'($urandom_range(9, 31));
      else if (r < 94) h = '0;
      else h = HL_W'($urandom_range(32, 63));
      inv = 1'($urandom_range(1));
      set_mode(h, inv);
      n = (h == 0) ? 2 : (h > 32) ? 64 : 2 * int'(h);
      sigs = (n == 64) ? 1 : $urandom_range(1, 4);
      pct = IDLE_PCT[phase % 4];
      repeat (sigs) begin
        repeat (n) begin
          if (sent < ITEM_TARGET) drive_sample(rand_sample(), 1'b0, '0, pct);
        end
      end
      if (n > 1 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, n - 1)) begin
          if (sent < ITEM_TARGET) drive_sample(rand_sample(), 1'b0, '0, pct);
        end
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d samples in %0d phases: %0d forward and %0d inverse signals completed,",
             n_items, phase, n_fwd_sig, n_inv_sig);
    $display("%0d coefficients compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/cdf97_pkg.sv
rtl/core/cdf97_lifting_1d_unit.sv
dv/cdf97_lifting_1d_unit_tb.sv
